// ===== design/tts_pkg.sv =====
`timescale 1ns / 1ps

package tts_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
    localparam int ID_W         = 8;
    localparam int TIME_W       = 32;
    localparam int OP_W         = 2;
    localparam int EV_W         = 3;
    localparam int SLOT_FIELD_W = 4;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL    = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
    localparam logic [OP_W-1:0] OP_DISP   = 2'd3;

    localparam logic [EV_W-1:0] EV_ADDED    = 3'd0;
    localparam logic [EV_W-1:0] EV_FULL     = 3'd1;
    localparam logic [EV_W-1:0] EV_DELETED  = 3'd2;
    localparam logic [EV_W-1:0] EV_RUN      = 3'd3;
    localparam logic [EV_W-1:0] EV_SCAN_END = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] per;
        logic              imm;
    } t_req;

    typedef struct packed {
        logic                    vld;
        logic [EV_W-1:0]         ev;
        logic [ID_W-1:0]         id;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    last;
    } t_res;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] per;
        logic              imm;
    } t_slot_rec;

    localparam int REC_W = $bits(t_slot_rec);

    // Low bits of a slot index, zero-extended when the index is narrower.
    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+SLOT_FIELD_W-1:0] t;
        t = {{SLOT_FIELD_W{1'b0}}, idx};
        return t[SLOT_FIELD_W-1:0];
    endfunction

endpackage

// ===== design/tts_slot_ram.sv =====
`timescale 1ns / 1ps

module tts_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data when no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tts_engine.sv =====
`timescale 1ns / 1ps

module tts_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tts_pkg::t_req i_req,
    output logic          o_busy,
    input  logic          i_out_free,
    output tts_pkg::t_res o_res
);
    import tts_pkg::*;

    logic                  r_busy;
    t_req                  r_req;
    logic [CNT_W-1:0]      r_rd_cnt;
    logic                  r_ev_vld;
    logic [SLOT_W-1:0]     r_ev_idx;
    logic                  r_hit;
    logic                  r_pos_vld;
    logic [SLOT_W-1:0]     r_pos;
    logic [SLOT_COUNT-1:0] r_active;
    logic [SLOT_COUNT-1:0] r_pending;
    logic [SLOT_COUNT-1:0] r_written;

    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic [REC_W-1:0]      rd_raw;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    t_slot_rec             wr_rec;

    t_slot_rec             cur;
    logic                  due_hit;
    logic                  ev_emit;
    logic                  final_stage;
    logic                  adv;
    logic                  add_ok;
    logic                  scan_open;

    tts_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (REC_W),
        .AW    (SLOT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_rec)
    );

    // a slot never written reads as the empty record
    assign cur = r_written[r_ev_idx] ? t_slot_rec'(rd_raw) : '0;

    assign due_hit = r_active[r_ev_idx] && (cur.due != '0) && (cur.due <= r_req.now);

    assign ev_emit = r_ev_vld && (((r_req.op == OP_UPDATE) && due_hit && cur.imm)
                                  || ((r_req.op == OP_DISP) && r_pending[r_ev_idx]));

    assign scan_open   = (r_rd_cnt != CNT_W'(SLOT_COUNT));
    assign final_stage = r_busy && !scan_open && !r_ev_vld;
    assign adv         = !(ev_emit && !i_out_free);
    assign rd_en       = r_busy && scan_open && adv;
    assign rd_addr     = r_rd_cnt[SLOT_W-1:0];
    assign add_ok      = (r_req.id != '0) && (r_hit || r_pos_vld);
    assign o_busy      = r_busy;

    // Update write-backs go to the slot under evaluation while the next one is
    // read, and an add writes after the scan, so read and write never share an entry.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ev_idx;
        wr_rec  = cur;
        if (r_ev_vld && adv && (r_req.op == OP_UPDATE) && due_hit) begin
            wr_en = 1'b1;
            if (cur.per != '0) begin
                wr_rec.due = r_req.now + cur.per;
            end else begin
                wr_rec.due = '0;
            end
        end else if (final_stage && i_out_free && (r_req.op == OP_ADD) && add_ok) begin
            wr_en   = 1'b1;
            wr_addr = r_pos;
            wr_rec  = '{id: r_req.id, due: r_req.now + r_req.delay,
                        per: r_req.per, imm: r_req.imm};
        end
    end

    always_comb begin
        o_res = '0;
        if (ev_emit) begin
            o_res = '{vld: 1'b1, ev: EV_RUN, id: cur.id,
                      slot: slot_field(r_ev_idx), last: 1'b0};
        end else if (final_stage) begin
            o_res.vld  = 1'b1;
            o_res.last = 1'b1;
            case (r_req.op)
                OP_ADD: begin
                    o_res.id = r_req.id;
                    if (add_ok) begin
                        o_res.ev   = EV_ADDED;
                        o_res.slot = slot_field(r_pos);
                    end else begin
                        o_res.ev = EV_FULL;
                    end
                end
                OP_DEL: begin
                    o_res.ev = EV_DELETED;
                    if (r_hit) begin
                        o_res.id   = r_req.id;
                        o_res.slot = slot_field(r_pos);
                    end
                end
                default: begin
                    o_res.ev = EV_SCAN_END;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_rd_cnt  <= '0;
            r_ev_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_pos_vld <= 1'b0;
            r_active  <= '0;
            r_pending <= '0;
            r_written <= '0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_rd_cnt  <= '0;
            r_ev_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_pos_vld <= 1'b0;
        end else if (r_busy) begin
            if (adv) begin
                r_ev_vld <= rd_en;
                if (rd_en) begin
                    r_rd_cnt <= r_rd_cnt + 1'b1;
                end
            end
            if (r_ev_vld && adv) begin
                case (r_req.op)
                    OP_ADD: begin
                        // an id match wins over an earlier free slot
                        if (!r_hit && (cur.id == r_req.id)) begin
                            r_hit <= 1'b1;
                        end else if (!r_hit && !r_pos_vld && !r_active[r_ev_idx]) begin
                            r_pos_vld <= 1'b1;
                        end
                    end
                    OP_DEL: begin
                        if (!r_hit && (cur.id == r_req.id)) begin
                            r_hit               <= 1'b1;
                            r_active[r_ev_idx]  <= 1'b0;
                            r_pending[r_ev_idx] <= 1'b0;
                        end
                    end
                    OP_UPDATE: begin
                        if (due_hit) begin
                            if (!cur.imm) begin
                                r_pending[r_ev_idx] <= 1'b1;
                            end
                            if (cur.per == '0) begin
                                r_active[r_ev_idx] <= 1'b0;
                            end
                        end
                    end
                    default: begin
                        r_pending[r_ev_idx] <= 1'b0;
                    end
                endcase
            end
            if (final_stage && i_out_free) begin
                r_busy <= 1'b0;
                if ((r_req.op == OP_ADD) && add_ok) begin
                    r_written[r_pos] <= 1'b1;
                    r_active[r_pos]  <= 1'b1;
                    r_pending[r_pos] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req <= i_req;
        end
        if (rd_en) begin
            r_ev_idx <= rd_addr;
        end
        if (r_busy && r_ev_vld && adv) begin
            if ((r_req.op == OP_ADD) && !r_hit && (cur.id == r_req.id)) begin
                r_pos <= r_ev_idx;
            end else if ((r_req.op == OP_ADD) && !r_hit && !r_pos_vld
                         && !r_active[r_ev_idx]) begin
                r_pos <= r_ev_idx;
            end else if ((r_req.op == OP_DEL) && !r_hit && (cur.id == r_req.id)) begin
                r_pos <= r_ev_idx;
            end
        end
    end

endmodule

// ===== design/timed_task_slot_scheduler.sv =====
`timescale 1ns / 1ps
// Timed task slot table with 16 slots (SLOT_COUNT in the package).
// Input channel (i_in_valid / o_in_ready) takes one request: add, delete,
// update timers or dispatch pending. Output channel (o_out_valid /
// i_out_ready) returns the results of that request in order; o_last marks
// the final one. Add and delete give one result; update gives one task-run
// result per due immediate slot and dispatch one per pending slot, in slot
// order, then a scan-end result. Each request scans all slots through the
// slot memory, one read per cycle while the output does not stall, with a
// registered read, and writes back the slot under evaluation while the next
// is read. The input stays busy until the last result of a request enters
// the output register, so a new request is accepted only after that. One
// request is in work at a time.
// Results sit in an output register; while the receiver stalls with that
// register full, the scan holds at the slot that wants to report.
// Reset clears all active, pending and written flags at once; unwritten slots
// read as empty (id 0, due 0), so the block accepts requests right after reset.

module timed_task_slot_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [tts_pkg::OP_W-1:0]          i_operation,
    input  logic [tts_pkg::ID_W-1:0]          i_task_id,
    input  logic [tts_pkg::TIME_W-1:0]        i_now_ms,
    input  logic [tts_pkg::TIME_W-1:0]        i_first_delay,
    input  logic [tts_pkg::TIME_W-1:0]        i_period,
    input  logic                              i_immediate,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [tts_pkg::EV_W-1:0]          o_event_res,
    output logic [tts_pkg::ID_W-1:0]          o_task_id_out,
    output logic [tts_pkg::SLOT_FIELD_W-1:0]  o_slot,
    output logic                              o_last
);
    import tts_pkg::*;

    logic  busy;
    logic  start;
    logic  out_free;
    t_req  req;
    t_res  res;

    logic                    r_out_valid;
    logic [EV_W-1:0]         r_event_res;
    logic [ID_W-1:0]         r_task_id_out;
    logic [SLOT_FIELD_W-1:0] r_slot;
    logic                    r_last;

    assign o_in_ready = !busy;
    assign start      = i_in_valid && !busy;
    assign out_free   = !r_out_valid || i_out_ready;

    assign req = '{op: i_operation, id: i_task_id, now: i_now_ms,
                   delay: i_first_delay, per: i_period, imm: i_immediate};

    tts_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (req),
        .o_busy     (busy),
        .i_out_free (out_free),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res.vld) begin
            r_event_res   <= res.ev;
            r_task_id_out <= res.id;
            r_slot        <= res.slot;
            r_last        <= res.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_event_res;
    assign o_task_id_out = r_task_id_out;
    assign o_slot        = r_slot;
    assign o_last        = r_last;

endmodule

// ===== dv/tts_table_monitor.sv =====
`timescale 1ns / 1ps

module tts_table_monitor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [tts_pkg::OP_W-1:0]          i_operation,
    input  logic [tts_pkg::ID_W-1:0]          i_task_id,
    input  logic [tts_pkg::TIME_W-1:0]        i_now_ms,
    input  logic [tts_pkg::TIME_W-1:0]        i_first_delay,
    input  logic [tts_pkg::TIME_W-1:0]        i_period,
    input  logic                              i_immediate,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [tts_pkg::EV_W-1:0]          i_event_res,
    input  logic [tts_pkg::ID_W-1:0]          i_task_id_out,
    input  logic [tts_pkg::SLOT_FIELD_W-1:0]  i_slot,
    input  logic                              i_last,
    output int                                o_fail_count,
    output int                                o_outstanding,
    output int                                o_results_checked
);

    import tts_pkg::*;

    typedef struct packed {
        logic [EV_W-1:0]         ev;
        logic [ID_W-1:0]         id;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    last;
    } t_run_report;

    // Shadow copy of the slot table
    logic [ID_W-1:0]   tbl_id      [SLOT_COUNT];
    logic [TIME_W-1:0] tbl_due     [SLOT_COUNT];
    logic [TIME_W-1:0] tbl_per     [SLOT_COUNT];
    logic              tbl_imm     [SLOT_COUNT];
    logic              tbl_active  [SLOT_COUNT];
    logic              tbl_pending [SLOT_COUNT];

    t_run_report report_q[$];
    t_run_report want;
    logic        bad;
    int          k;

    task automatic push_report(input logic [EV_W-1:0] ev, input logic [ID_W-1:0] id,
                               input int idx, input logic fin);
        t_run_report r;
        r.ev   = ev;
        r.id   = id;
        r.slot = idx[SLOT_FIELD_W-1:0];
        r.last = fin;
        report_q.push_back(r);
    endtask

    task automatic run_table_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] now,
                                input logic [TIME_W-1:0] delay,
                                input logic [TIME_W-1:0] per, input logic imm);
        int   pos;
        int   s;
        logic hit;
        pos = -1;
        hit = 1'b0;
        case (op)
            OP_ADD: begin
                // Slot with the same id wins; else the first inactive one
                if (id != '0) begin
                    for (s = 0; s < SLOT_COUNT; s++) begin
                        if (!hit) begin
                            if (tbl_id[s] == id) begin
                                pos = s;
                                hit = 1'b1;
                            end else if (pos < 0 && !tbl_active[s]) begin
                                pos = s;
                            end
                        end
                    end
                end
                if (pos < 0) begin
                    push_report(EV_FULL, id, 0, 1'b1);
                end else begin
                    tbl_id[pos]      = id;
                    tbl_due[pos]     = now + delay;
                    tbl_per[pos]     = per;
                    tbl_pending[pos] = 1'b0;
                    tbl_imm[pos]     = imm;
                    tbl_active[pos]  = 1'b1;
                    push_report(EV_ADDED, id, pos, 1'b1);
                end
            end
            OP_DEL: begin
                for (s = 0; s < SLOT_COUNT; s++) begin
                    if (!hit && tbl_id[s] == id) begin
                        hit            = 1'b1;
                        tbl_active[s]  = 1'b0;
                        tbl_pending[s] = 1'b0;
                        push_report(EV_DELETED, id, s, 1'b1);
                    end
                end
                if (!hit) push_report(EV_DELETED, '0, 0, 1'b1);
            end
            OP_UPDATE: begin
                for (s = 0; s < SLOT_COUNT; s++) begin
                    if (tbl_active[s] && tbl_due[s] != '0 && tbl_due[s] <= now) begin
                        tbl_due[s] = '0;
                        if (tbl_imm[s]) push_report(EV_RUN, tbl_id[s], s, 1'b0);
                        else tbl_pending[s] = 1'b1;
                        // Re-arm periodic tasks, retire one-shots
                        if (tbl_per[s] != '0) tbl_due[s] = now + tbl_per[s];
                        else tbl_active[s] = 1'b0;
                    end
                end
                push_report(EV_SCAN_END, '0, 0, 1'b1);
            end
            default: begin
                for (s = 0; s < SLOT_COUNT; s++) begin
                    if (tbl_pending[s]) begin
                        tbl_pending[s] = 1'b0;
                        push_report(EV_RUN, tbl_id[s], s, 1'b0);
                    end
                end
                push_report(EV_SCAN_END, '0, 0, 1'b1);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (k = 0; k < SLOT_COUNT; k++) begin
                tbl_id[k]      = '0;
                tbl_due[k]     = '0;
                tbl_per[k]     = '0;
                tbl_imm[k]     = 1'b0;
                tbl_active[k]  = 1'b0;
                tbl_pending[k] = 1'b0;
            end
            report_q.delete();
            o_fail_count      = 0;
            o_results_checked = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                run_table_op(i_operation, i_task_id, i_now_ms, i_first_delay, i_period,
                             i_immediate);
            end
            if (i_out_valid && i_out_ready) begin
                o_results_checked++;
                if (report_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %0d/%0d/%0d/%0b",
                             $time, i_event_res, i_task_id_out, i_slot, i_last);
                    o_fail_count++;
                end else begin
                    want = report_q.pop_front();
                    bad  = 1'b0;
                    if (want.ev !== i_event_res) begin
                        $display("%0t tts_table_monitor: event mismatch, expected %0d, actual %0d",
                                 $time, want.ev, i_event_res);
                        bad = 1'b1;
                    end
                    if (want.id !== i_task_id_out) begin
                        $display("%0t tts_table_monitor: task id mismatch, expected %0d, actual %0d",
                                 $time, want.id, i_task_id_out);
                        bad = 1'b1;
                    end
                    if (want.slot !== i_slot) begin
                        $display("%0t tts_table_monitor: slot mismatch, expected %0d, actual %0d",
                                 $time, want.slot, i_slot);
                        bad = 1'b1;
                    end
                    if (want.last !== i_last) begin
                        $display("%0t tts_table_monitor: last mismatch, expected %0b, actual %0b",
                                 $time, want.last, i_last);
                        bad = 1'b1;
                    end
                    if (bad) o_fail_count++;
                end
            end
        end
        o_outstanding = report_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import tts_pkg::*;

    localparam int RAND_ITEMS  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 40;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_operation;
    logic [ID_W-1:0]         i_task_id;
    logic [TIME_W-1:0]       i_now_ms;
    logic [TIME_W-1:0]       i_first_delay;
    logic [TIME_W-1:0]       i_period;
    logic                    i_immediate;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [EV_W-1:0]         o_event_res;
    logic [ID_W-1:0]         o_task_id_out;
    logic [SLOT_FIELD_W-1:0] o_slot;
    logic                    o_last;

    int fail_count;
    int outstanding;
    int results_checked;
    int sent_count;
    int directed_count;
    int stall_cycles;
    bit steady;
    bit hold_off_req;

    timed_task_slot_scheduler u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_task_id    (i_task_id),
        .i_now_ms     (i_now_ms),
        .i_first_delay(i_first_delay),
        .i_period     (i_period),
        .i_immediate  (i_immediate),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_res  (o_event_res),
        .o_task_id_out(o_task_id_out),
        .o_slot       (o_slot),
        .o_last       (o_last)
    );

    tts_table_monitor u_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_task_id        (i_task_id),
        .i_now_ms         (i_now_ms),
        .i_first_delay    (i_first_delay),
        .i_period         (i_period),
        .i_immediate      (i_immediate),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_event_res      (o_event_res),
        .i_task_id_out    (o_task_id_out),
        .i_slot           (o_slot),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_results_checked(results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done   = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= 31);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] now,
                                input logic [TIME_W-1:0] delay,
                                input logic [TIME_W-1:0] per, input logic imm);
        if (!steady) begin
            while ($urandom_range(99) < 31) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_task_id     <= id;
        i_now_ms      <= now;
        i_first_delay <= delay;
        i_period      <= per;
        i_immediate   <= imm;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Hold the request line low until every outstanding result has arrived
    task automatic drain_pause();
        i_in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge i_clk);
    endtask

    initial begin
        int                r;
        int                n;
        int                i;
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] clock_ms;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = OP_ADD;
        i_task_id     = '0;
        i_now_ms      = '0;
        i_first_delay = '0;
        i_period      = '0;
        i_immediate   = 1'b0;
        sent_count    = 0;
        steady        = 1'b0;
        hold_off_req  = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table: scans report only their end, id zero is refused,
        // delete of id zero hits the first empty slot, unknown id misses
        send_request(OP_DISP, 8'd0, '0, '0, '0, 1'b0);
        send_request(OP_UPDATE, 8'd0, '0, '0, '0, 1'b0);
        send_request(OP_ADD, 8'd0, '0, 32'd5, 32'd5, 1'b1);
        send_request(OP_DEL, 8'd0, '0, '0, '0, 1'b0);
        send_request(OP_DEL, 8'd77, '0, '0, '0, 1'b0);

        // Fill every slot with a mix of modes; id 15 arms at the top of the
        // time range and id 16 wraps to a due time of zero
        for (i = 1; i <= SLOT_COUNT; i++) begin
            if (i == 15)
                send_request(OP_ADD, 8'(i), '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
            else if (i == 16)
                send_request(OP_ADD, 8'(i), 32'hFFFF_FFF0, 32'h10, 32'd7, 1'b0);
            else if (i == 14)
                send_request(OP_ADD, 8'(i), '0, 32'(i), 32'hFFFF_FFFF, 1'b0);
            else
                send_request(OP_ADD, 8'(i), '0, 32'(i), (i % 3 == 0) ? 32'd0 : 32'd10,
                             i[0]);
        end
        send_request(OP_ADD, 8'd255, '0, '0, '0, 1'b0);
        send_request(OP_UPDATE, 8'd0, 32'd100, '0, '0, 1'b0);
        send_request(OP_DISP, 8'd0, 32'd100, '0, '0, 1'b0);
        send_request(OP_UPDATE, 8'd0, 32'hFFFF_FFFF, '0, '0, 1'b0);
        send_request(OP_DEL, 8'd3, '0, '0, '0, 1'b0);
        directed_count = sent_count;
        drain_pause();

        clock_ms = 32'd200;
        for (n = 0; n < RAND_ITEMS; n++) begin
            steady = (n >= 100 && n < 160);
            if (n == 200) hold_off_req = 1'b1;
            if (n == 250) drain_pause();

            r = $urandom_range(99);
            if (r < 40) op = OP_ADD;
            else if (r < 55) op = OP_DEL;
            else if (r < 85) op = OP_UPDATE;
            else op = OP_DISP;

            r = $urandom_range(99);
            if (r < 75) id = 8'($urandom_range(1, 20));
            else if (r < 90) id = 8'($urandom_range(0, 255));
            else id = $urandom_range(1) ? 8'd255 : 8'd0;

            // Mostly a steadily advancing clock, now and then a wild time value
            clock_ms = clock_ms + 32'($urandom_range(0, 30));
            now = ($urandom_range(99) < 4) ? $urandom : clock_ms;
            delay = ($urandom_range(99) < 85) ? 32'($urandom_range(0, 100)) : $urandom;

            r = $urandom_range(99);
            if (r < 50) per = '0;
            else if (r < 90) per = 32'($urandom_range(1, 80));
            else per = $urandom;

            send_request(op, id, now, delay, per, 1'($urandom_range(1)));
        end

        i_in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE) @(posedge i_clk);

        $display("tb_top: %0d requests sent (%0d directed), %0d results checked",
                 sent_count, directed_count, results_checked);
        $display("tb_top: full table, id zero, due-time wrap, long output stall and drains run");
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
